// ----- sv/text_console_cursor_engine_defines.svh -----
// Assertion macros for the checker of the console engine.
// Each check samples on the rising clock edge and is off while reset is asserted.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define TCCE_CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define TCCE_CHK_NEXT(label, pre, post, msg) \
	`TCCE_CHK(label, (pre) |=> (post), msg)

`endif

// ----- sv/tcce_pkg.sv -----
package tcce_pkg;

	// Default screen geometry and tab stop spacing.
	localparam int COLUMNS_DEF   = 80;
	localparam int ROWS_DEF      = 25;
	localparam int TAB_WIDTH_DEF = 8;

	// Port field widths.
	localparam int FUNC_W = 2;
	localparam int CHAR_W = 8;
	localparam int RROW_W = 5;
	localparam int RCOL_W = 7;
	localparam int OCOL_W = 7;
	localparam int OROW_W = 5;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;

	// Configuration port geometry and register map.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_ATTR = '0;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// Character codes with special handling.
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'hFF;

	// Reset values.
	localparam logic [CELL_W-1:0] CELL_INIT  = 16'h0F20;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	// Kind of full-screen sweep in progress.
	typedef enum logic [1:0] {
		SWEEP_INIT,
		SWEEP_CLEAR,
		SWEEP_SCROLL
	} sweep_mode_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic        accept;
		logic        exec;
		logic        sweep_run;
		sweep_mode_t sweep_mode;
	} tcce_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic scroll;
		logic sweep_last;
	} tcce_sts_t;

endpackage

// ----- sv/tcce_ram.sv -----
module tcce_ram #(
	parameter int DEPTH  = tcce_pkg::ROWS_DEF * tcce_pkg::COLUMNS_DEF,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = tcce_pkg::CELL_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/tcce_ctrl.sv -----
module tcce_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tcce_pkg::FUNC_W-1:0]   func,
	input  tcce_pkg::tcce_sts_t           sts,
	output tcce_pkg::tcce_cmd_t           cmd,
	output logic                          busy,
	output logic                          done
);

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC,
		ST_FINISH
	} state_t;

	state_t                state_q;
	tcce_pkg::sweep_mode_t mode_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  accept;

	assign accept = (state_q == ST_IDLE) && start;

	// Commands follow directly from the state.
	always_comb begin
		cmd.accept     = accept;
		cmd.exec       = (state_q == ST_EXEC);
		cmd.sweep_run  = (state_q == ST_SWEEP);
		cmd.sweep_mode = mode_q;
	end

	// Sequencer: reset runs the initial clearing sweep before the first beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			mode_q  <= tcce_pkg::SWEEP_INIT;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						busy_q <= 1'b1;
						if (func == tcce_pkg::FUNC_CLEAR) begin
							state_q <= ST_SWEEP;
							mode_q  <= tcce_pkg::SWEEP_CLEAR;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (sts.scroll) begin
						state_q <= ST_SWEEP;
						mode_q  <= tcce_pkg::SWEEP_SCROLL;
					end else begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				ST_SWEEP: begin
					if (sts.sweep_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// The last sweep write lands in this cycle.
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= (mode_q != tcce_pkg::SWEEP_INIT);
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- sv/tcce_dp.sv -----
module tcce_dp #(
	parameter int COLUMNS   = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcce_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcce_pkg::tcce_cmd_t           cmd,
	output tcce_pkg::tcce_sts_t           sts,
	input  logic [tcce_pkg::FUNC_W-1:0]   func,
	input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcce_pkg::RROW_W-1:0]   read_row,
	input  logic [tcce_pkg::RCOL_W-1:0]   read_col,
	input  logic                          cfg_wr,
	input  logic [tcce_pkg::ATTR_W-1:0]   cfg_wdata,
	output logic [tcce_pkg::ATTR_W-1:0]   attr,
	output logic [tcce_pkg::OCOL_W-1:0]   cursor_col,
	output logic [tcce_pkg::OROW_W-1:0]   cursor_row,
	output logic [tcce_pkg::IDX_W-1:0]    cursor_index,
	output logic [tcce_pkg::CELL_W-1:0]   cell_value
);

	localparam int CELLS    = ROWS * COLUMNS;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int COL_W    = $clog2(COLUMNS);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int PH_W     = $clog2(TAB_WIDTH);
	localparam int NC_W     = $clog2(COLUMNS + TAB_WIDTH);
	localparam int COPY_END = CELLS - COLUMNS;
	localparam int CELL_W   = tcce_pkg::CELL_W;
	localparam int CHAR_W   = tcce_pkg::CHAR_W;

	// Cursor, tab phase (column modulo tab width) and attribute.
	logic [COL_W-1:0]           col_q;
	logic [ROW_W-1:0]           row_q;
	logic [PH_W-1:0]            ph_q;
	logic [tcce_pkg::ATTR_W-1:0] attr_q;

	// Latched command beat.
	logic [tcce_pkg::FUNC_W-1:0] func_q;
	logic [CHAR_W-1:0]          char_q;
	logic                       rd_ok_q;
	logic [CELL_W-1:0]          cell_q;

	// Sweep counter and the write stage behind the registered read.
	logic [ADDR_W-1:0]          sweep_q;
	logic                       wr_vld_s1;
	logic                       wr_copy_s1;
	logic [ADDR_W-1:0]          wr_addr_s1;
	logic [CELL_W-1:0]          wr_fill_s1;

	// Memory port signals.
	logic                       ram_we;
	logic [ADDR_W-1:0]          ram_waddr;
	logic [CELL_W-1:0]          ram_wdata;
	logic [ADDR_W-1:0]          ram_raddr;
	logic [CELL_W-1:0]          ram_rdata;

	// Put-character next state.
	logic [NC_W-1:0]            ncol;
	logic [PH_W-1:0]            nph;
	logic [ROW_W-1:0]           nrow;
	logic                       inc_row;
	logic                       scroll_c;
	logic                       put_we;
	logic [COL_W-1:0]           wcol;
	logic [CHAR_W-1:0]          wchar;
	logic [ADDR_W-1:0]          put_addr;
	logic                       is_put;

	// Read and sweep addressing.
	logic [31:0]                rd_lin;
	logic                       rd_ok;
	logic [ADDR_W-1:0]          port_addr;
	logic                       sweep_copy;
	logic [ADDR_W-1:0]          sweep_rd;
	logic [CELL_W-1:0]          fill_val;

	assign is_put = (func_q == tcce_pkg::FUNC_PUT);

	// Cursor movement for one put-character beat.
	always_comb begin
		ncol    = NC_W'(col_q);
		nph     = ph_q;
		inc_row = 1'b0;
		put_we  = 1'b0;
		wcol    = col_q;
		wchar   = char_q;
		case (char_q)
			tcce_pkg::CH_BS: begin
				if (col_q != '0) begin
					ncol   = NC_W'(col_q) - 1'b1;
					nph    = (ph_q == '0) ? PH_W'(TAB_WIDTH - 1) : ph_q - 1'b1;
					put_we = 1'b1;
					wcol   = col_q - 1'b1;
					wchar  = tcce_pkg::CH_BLANK;
				end
			end
			tcce_pkg::CH_TAB: begin
				ncol = NC_W'(col_q) + NC_W'(TAB_WIDTH) - NC_W'(ph_q);
				nph  = '0;
			end
			tcce_pkg::CH_CR: begin
				ncol = '0;
				nph  = '0;
			end
			tcce_pkg::CH_LF: begin
				ncol    = '0;
				nph     = '0;
				inc_row = 1'b1;
			end
			default: begin
				// Printable codes are stored; other control codes leave the cursor.
				if (char_q inside {[tcce_pkg::CH_BLANK:tcce_pkg::CH_LAST]}) begin
					put_we = 1'b1;
					ncol   = NC_W'(col_q) + 1'b1;
					nph    = (ph_q == PH_W'(TAB_WIDTH - 1)) ? '0 : ph_q + 1'b1;
				end
			end
		endcase
		// Wrap past the last column.
		if (ncol >= NC_W'(COLUMNS)) begin
			ncol    = '0;
			nph     = '0;
			inc_row = 1'b1;
		end
		// Past the last row the screen scrolls and the cursor stays on the last row.
		nrow     = row_q;
		scroll_c = 1'b0;
		if (inc_row) begin
			if (row_q == ROW_W'(ROWS - 1)) begin
				scroll_c = 1'b1;
			end else begin
				nrow = row_q + 1'b1;
			end
		end
		put_addr = ADDR_W'(32'(row_q) * 32'(COLUMNS) + 32'(wcol));
	end

	// Cell address of a read beat, taken straight from the ports.
	always_comb begin
		rd_lin    = 32'(read_row) * 32'(COLUMNS) + 32'(read_col);
		rd_ok     = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));
		port_addr = rd_ok ? ADDR_W'(rd_lin) : '0;
	end

	// A scroll copies each cell from one row below, then blanks the bottom row.
	always_comb begin
		sweep_copy = (cmd.sweep_mode == tcce_pkg::SWEEP_SCROLL) &&
			(sweep_q < ADDR_W'(COPY_END));
		sweep_rd   = ADDR_W'({1'b0, sweep_q} + (ADDR_W + 1)'(COLUMNS));
		fill_val   = (cmd.sweep_mode == tcce_pkg::SWEEP_INIT) ? tcce_pkg::CELL_INIT :
			{attr_q, tcce_pkg::CH_BLANK};
	end

	// Memory port selection: sweep writes, else the put-character write.
	always_comb begin
		ram_raddr = cmd.sweep_run ? (sweep_copy ? sweep_rd : sweep_q) : port_addr;
		ram_we    = wr_vld_s1 || (cmd.exec && is_put && put_we);
		ram_waddr = wr_vld_s1 ? wr_addr_s1 : put_addr;
		if (wr_vld_s1) begin
			ram_wdata = wr_copy_s1 ? ram_rdata : wr_fill_s1;
		end else begin
			ram_wdata = {attr_q, wchar};
		end
	end

	assign sts.scroll     = is_put && scroll_c;
	assign sts.sweep_last = (sweep_q == ADDR_W'(CELLS - 1));

	// Cursor, attribute, result and sweep control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			ph_q      <= '0;
			attr_q    <= tcce_pkg::ATTR_RESET;
			cell_q    <= '0;
			sweep_q   <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			if (cfg_wr) begin
				attr_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				cell_q  <= '0;
				sweep_q <= '0;
				if (func == tcce_pkg::FUNC_CLEAR) begin
					col_q <= '0;
					row_q <= '0;
					ph_q  <= '0;
				end
			end
			if (cmd.exec) begin
				if (is_put) begin
					col_q <= COL_W'(ncol);
					row_q <= nrow;
					ph_q  <= nph;
				end
				cell_q <= (func_q == tcce_pkg::FUNC_READ && rd_ok_q) ? ram_rdata : '0;
			end
			if (cmd.sweep_run) begin
				sweep_q <= sweep_q + 1'b1;
			end
			wr_vld_s1 <= cmd.sweep_run;
		end
	end

	// Payload registers of the command beat and the sweep write stage.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= func;
			char_q  <= char_code;
			rd_ok_q <= rd_ok;
		end
		wr_copy_s1 <= sweep_copy;
		wr_addr_s1 <= sweep_q;
		wr_fill_s1 <= fill_val;
	end

	tcce_ram #(
		.DEPTH (CELLS),
		.ADDR_W(ADDR_W),
		.DATA_W(CELL_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign attr         = attr_q;
	assign cursor_col   = tcce_pkg::OCOL_W'(col_q);
	assign cursor_row   = tcce_pkg::OROW_W'(row_q);
	assign cursor_index = tcce_pkg::IDX_W'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
	assign cell_value   = cell_q;

endmodule

// ----- sv/text_console_cursor_engine.sv -----
// Put-character, read and ignored beats: a beat is taken only while busy is low, runs in the exec
// state; done pulses on the return to idle. A put that scrolls also runs the row-shift sweep of
// the cell memory port first. Clear screen: done pulses once the one-write-a-cycle fill ends.
// After reset busy stays high while every cell is set to 0x0F20.
// Results are not held off by the receiver; each done pulse lasts one cycle.
module text_console_cursor_engine #(
	parameter int COLUMNS   = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcce_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [tcce_pkg::FUNC_W-1:0]    func,
	input  logic [tcce_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcce_pkg::RROW_W-1:0]    read_row,
	input  logic [tcce_pkg::RCOL_W-1:0]    read_col,
	output logic                           done,
	output logic [tcce_pkg::OCOL_W-1:0]    cursor_col,
	output logic [tcce_pkg::OROW_W-1:0]    cursor_row,
	output logic [tcce_pkg::IDX_W-1:0]     cursor_index,
	output logic [tcce_pkg::CELL_W-1:0]    cell_value,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tcce_pkg::PADDR_W-1:0]   paddr,
	input  logic [tcce_pkg::PDATA_W-1:0]   pwdata,
	output logic [tcce_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	tcce_pkg::tcce_cmd_t           cmd;
	tcce_pkg::tcce_sts_t           sts;
	logic                          cfg_wr;
	logic                          attr_sel;
	logic [tcce_pkg::ATTR_W-1:0]   attr;

	// Register decode on the word index of the byte address.
	assign attr_sel = (paddr[tcce_pkg::PADDR_W-1:2] == tcce_pkg::REG_ATTR);
	assign cfg_wr   = psel && penable && pwrite && attr_sel;
	assign pready   = 1'b1;
	assign prdata   = attr_sel ? tcce_pkg::PDATA_W'(attr) : '0;

	tcce_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	tcce_dp #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.char_code   (char_code),
		.read_row    (read_row),
		.read_col    (read_col),
		.cfg_wr      (cfg_wr),
		.cfg_wdata   (pwdata[tcce_pkg::ATTR_W-1:0]),
		.attr        (attr),
		.cursor_col  (cursor_col),
		.cursor_row  (cursor_row),
		.cursor_index(cursor_index),
		.cell_value  (cell_value)
	);

endmodule

// ----- sv/tcce_checker.sv -----
`include "text_console_cursor_engine_defines.svh"

module tcce_checker #(
	parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [tcce_pkg::OCOL_W-1:0] cursor_col,
	input logic [tcce_pkg::OROW_W-1:0] cursor_row
);

	// Done is set only on the way from exec or finish back to idle, so result pulses never abut.
	`TCCE_CHK_NEXT(a_done_single, done, !done, "done held for two cycles")

	// An accepted beat makes the engine busy in the next cycle.
	`TCCE_CHK_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

	// A result is only presented once the engine is free for the next beat.
	`TCCE_CHK(a_done_idle, done |-> !busy, "done while busy")

	// The reported cursor always lies on the screen.
	`TCCE_CHK(a_cursor_range, done |-> (32'(cursor_col) < COLUMNS && 32'(cursor_row) < ROWS), "cursor off screen")

endmodule

bind text_console_cursor_engine tcce_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cursor_col(cursor_col),
	.cursor_row(cursor_row)
);

// ----- verif/testbench.sv -----
module testbench;
	import tcce_pkg::*;

	localparam int COLS  = COLUMNS_DEF;
	localparam int LINES = ROWS_DEF;
	localparam int TABW  = TAB_WIDTH_DEF;
	localparam int CELLS = COLS * LINES;

	// The one operation code that the block leaves unused.
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	// Random items per attribute setting.
	localparam int PHASE_BEATS = 280;

	typedef enum logic [1:0] {
		CMD_BEAT,
		CMD_SETTLE,
		CMD_ATTR_WRITE
	} cmd_kind_t;

	typedef struct {
		cmd_kind_t         kind;
		logic [FUNC_W-1:0] op;
		logic [CHAR_W-1:0] ch;
		logic [RROW_W-1:0] rr;
		logic [RCOL_W-1:0] rc;
		logic [ATTR_W-1:0] attr;
	} console_cmd_t;

	typedef struct packed {
		logic [OCOL_W-1:0] col;
		logic [OROW_W-1:0] row;
		logic [IDX_W-1:0]  index;
		logic [CELL_W-1:0] cell_word;
	} cursor_report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [FUNC_W-1:0]   func = FUNC_PUT;
	logic [CHAR_W-1:0]   char_code = '0;
	logic [RROW_W-1:0]   read_row = '0;
	logic [RCOL_W-1:0]   read_col = '0;
	logic                done;
	logic [OCOL_W-1:0]   cursor_col;
	logic [OROW_W-1:0]   cursor_row;
	logic [IDX_W-1:0]    cursor_index;
	logic [CELL_W-1:0]   cell_value;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	text_console_cursor_engine u_top (.*);

	// Screen, cursor and attribute as the block should hold them.
	logic [CELL_W-1:0] screen_model [0:CELLS-1];
	int                cur_col;
	int                cur_row;
	logic [ATTR_W-1:0] attr_model;

	console_cmd_t   pending_cmds [$];
	cursor_report_t pending_reports [$];
	console_cmd_t   head_cmd;
	cursor_report_t got_report;
	cursor_report_t want_report;
	int             mismatch_count = 0;
	int             queued_beats = 0;
	logic           took_beat = 1'b0;
	int             idle_left = 0;
	logic [1:0]     apb_step = 2'd0;
	logic           calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the screen model and return the report it yields.
	function automatic cursor_report_t predict_cursor_report(
		input logic [FUNC_W-1:0] op,
		input logic [CHAR_W-1:0] ch,
		input logic [RROW_W-1:0] rr,
		input logic [RCOL_W-1:0] rc
	);
		cursor_report_t rep;
		int             i;
		rep.cell_word = '0;
		case (op)
			FUNC_PUT: begin
				if (ch == CH_BS) begin
					if (cur_col != 0) begin
						cur_col--;
						screen_model[cur_row * COLS + cur_col] = {attr_model, CH_BLANK};
					end
				end else if (ch == CH_TAB) begin
					cur_col = cur_col + TABW - (cur_col % TABW);
				end else if (ch == CH_CR) begin
					cur_col = 0;
				end else if (ch == CH_LF) begin
					cur_col = 0;
					cur_row++;
				end else if (ch >= CH_BLANK) begin
					screen_model[cur_row * COLS + cur_col] = {attr_model, ch};
					cur_col++;
				end
				// Wrap past the last column, then scroll past the last row.
				if (cur_col >= COLS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= LINES) begin
					for (i = 0; i < CELLS - COLS; i++)
						screen_model[i] = screen_model[i + COLS];
					for (i = CELLS - COLS; i < CELLS; i++)
						screen_model[i] = {attr_model, CH_BLANK};
					cur_row = LINES - 1;
				end
			end
			FUNC_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen_model[i] = {attr_model, CH_BLANK};
				cur_col = 0;
				cur_row = 0;
			end
			FUNC_READ: begin
				if (rr < LINES && rc < COLS)
					rep.cell_word = screen_model[rr * COLS + rc];
			end
			default: begin
			end
		endcase
		rep.col   = cur_col;
		rep.row   = cur_row;
		rep.index = cur_row * COLS + cur_col;
		return rep;
	endfunction

	task automatic queue_beat(
		input logic [FUNC_W-1:0] op,
		input logic [CHAR_W-1:0] ch,
		input logic [RROW_W-1:0] rr,
		input logic [RCOL_W-1:0] rc
	);
		console_cmd_t c;
		c.kind = CMD_BEAT;
		c.op   = op;
		c.ch   = ch;
		c.rr   = rr;
		c.rc   = rc;
		c.attr = '0;
		pending_cmds.push_back(c);
		queued_beats++;
	endtask

	// Put a character; the read fields carry random values that must be ignored.
	task automatic queue_put(input logic [CHAR_W-1:0] ch);
		queue_beat(FUNC_PUT, ch, $urandom_range(0, 31), $urandom_range(0, 127));
	endtask

	// Reads favor the bottom row, where scrolled text collects.
	task automatic queue_random_read();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			queue_beat(FUNC_READ, $urandom, LINES - 1, $urandom_range(0, COLS - 1));
		else if (pick < 8)
			queue_beat(FUNC_READ, $urandom, $urandom_range(0, LINES - 1),
				$urandom_range(0, COLS - 1));
		else if (pick == 8)
			queue_beat(FUNC_READ, $urandom, $urandom_range(LINES, 31),
				$urandom_range(0, 127));
		else
			queue_beat(FUNC_READ, $urandom, $urandom_range(0, 31),
				$urandom_range(COLS, 127));
	endtask

	// Drain all results, then write the attribute register.
	task automatic queue_attr(input logic [ATTR_W-1:0] value);
		console_cmd_t c;
		c.kind = CMD_SETTLE;
		c.op   = FUNC_PUT;
		c.ch   = '0;
		c.rr   = '0;
		c.rc   = '0;
		c.attr = value;
		pending_cmds.push_back(c);
		c.kind = CMD_ATTR_WRITE;
		pending_cmds.push_back(c);
	endtask

	// A line of text with occasional tabs, backspaces and reads, then CR LF, LF or no line end.
	task automatic queue_text_line();
		int len;
		int k;
		int roll;
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 30);
		for (k = 0; k < len; k++) begin
			roll = $urandom_range(0, 29);
			if (roll == 0)
				queue_put(CH_TAB);
			else if (roll == 1)
				queue_put(CH_BS);
			else if (roll < 6)
				queue_random_read();
			else
				queue_put($urandom_range(32, 255));
		end
		roll = $urandom_range(0, 3);
		if (roll == 1) begin
			queue_put(CH_CR);
			queue_put(CH_LF);
		end else if (roll > 1) begin
			queue_put(CH_LF);
		end
	endtask

	task automatic queue_random_phase(input int count);
		int first;
		int roll;
		first = queued_beats;
		while (queued_beats - first < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				queue_text_line();
			else if (roll < 82)
				queue_random_read();
			else if (roll < 90)
				queue_put($urandom_range(0, 255));
			else if (roll < 96)
				queue_beat(FUNC_SPARE, $urandom, $urandom, $urandom);
			else
				queue_beat(FUNC_CLEAR, $urandom, $urandom, $urandom);
		end
	endtask

	// Driver: beats and register writes change at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (apb_step == 2'd1) begin
				penable  <= 1'b1;
				apb_step <= 2'd2;
			end else if (apb_step == 2'd2) begin
				psel     <= 1'b0;
				penable  <= 1'b0;
				pwrite   <= 1'b0;
				apb_step <= 2'd0;
			end else if (start && !took_beat) begin
				// The beat is still waiting for the block.
			end else if (idle_left != 0) begin
				start     <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_cmds.size() == 0) begin
				start <= 1'b0;
			end else begin
				head_cmd = pending_cmds[0];
				case (head_cmd.kind)
					CMD_BEAT: begin
						func      <= head_cmd.op;
						char_code <= head_cmd.ch;
						read_row  <= head_cmd.rr;
						read_col  <= head_cmd.rc;
						start     <= 1'b1;
						void'(pending_cmds.pop_front());
						if ($urandom_range(0, 39) == 0)
							calm <= !calm;
						idle_left <= calm ? 0 : $urandom_range(0, 7);
					end
					CMD_SETTLE: begin
						start <= 1'b0;
						if (pending_reports.size() == 0 && !busy) begin
							void'(pending_cmds.pop_front());
							idle_left <= 2;
						end
					end
					default: begin
						start    <= 1'b0;
						psel     <= 1'b1;
						pwrite   <= 1'b1;
						penable  <= 1'b0;
						paddr    <= {REG_ATTR, 2'b00};
						pwdata   <= {{(PDATA_W - ATTR_W){1'b0}}, head_cmd.attr};
						apb_step <= 2'd1;
						void'(pending_cmds.pop_front());
					end
				endcase
			end
		end
	end

	// Monitor: check results, then record accepted beats and register writes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				got_report = '{cursor_col, cursor_row, cursor_index, cell_value};
				if (pending_reports.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: col %0d row %0d index %0d cell %h",
							cursor_col, cursor_row, cursor_index, cell_value);
				end else begin
					want_report = pending_reports.pop_front();
					if (got_report.col !== want_report.col ||
							got_report.row !== want_report.row ||
							got_report.index !== want_report.index ||
							got_report.cell_word !== want_report.cell_word) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: expected col %0d row %0d index %0d cell %h, %s",
								want_report.col, want_report.row, want_report.index,
								want_report.cell_word,
								$sformatf("got col %0d row %0d index %0d cell %h",
									got_report.col, got_report.row, got_report.index,
									got_report.cell_word));
					end
				end
			end
			if (start && !busy) begin
				pending_reports.push_back(
					predict_cursor_report(func, char_code, read_row, read_col));
				took_beat <= 1'b1;
			end else begin
				took_beat <= 1'b0;
			end
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_ATTR)
				attr_model = pwdata[ATTR_W-1:0];
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int waited;
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = CELL_INIT;
		cur_col    = 0;
		cur_row    = 0;
		attr_model = ATTR_RESET;

		// Directed part under the reset attribute.
		queue_beat(FUNC_READ, 8'h00, 0, 0);
		queue_put(8'h41);
		queue_put(CH_LAST);
		queue_put(CH_BLANK);
		queue_put(8'h00);
		queue_put(8'h1F);
		queue_put(CH_BS);
		queue_beat(FUNC_READ, 8'hFF, 0, 2);
		queue_put(CH_CR);
		queue_put(CH_BS);
		queue_put(CH_TAB);
		queue_put(CH_TAB);
		queue_put(CH_LF);
		queue_beat(FUNC_READ, 8'h00, LINES - 1, COLS - 1);
		queue_beat(FUNC_READ, 8'h00, 31, 127);
		queue_beat(FUNC_READ, 8'h00, 0, 127);
		queue_beat(FUNC_READ, 8'h00, 31, 0);
		queue_beat(FUNC_SPARE, 8'hA5, 5'h15, 7'h2A);
		queue_put(8'h5A);
		queue_beat(FUNC_CLEAR, 8'hFF, 31, 127);
		queue_beat(FUNC_READ, 8'h00, 0, 0);

		// Random part across several attribute settings, extremes included.
		queue_attr(8'h00);
		queue_random_phase(PHASE_BEATS);
		queue_attr(8'hFF);
		queue_random_phase(PHASE_BEATS);
		queue_attr($urandom_range(0, 255));
		queue_random_phase(PHASE_BEATS);
		queue_attr(8'h0F);
		queue_random_phase(PHASE_BEATS);
		queue_attr($urandom_range(0, 255));
		queue_random_phase(PHASE_BEATS);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || start || apb_step != 2'd0)
			@(posedge clk);
		waited = 0;
		while (pending_reports.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Upper bound on the run, far above a slow but correct one.
	initial begin
		#150_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ----- text_console_cursor_engine.f -----
+incdir+sv
sv/tcce_pkg.sv
sv/tcce_ram.sv
sv/tcce_ctrl.sv
sv/tcce_dp.sv
sv/text_console_cursor_engine.sv
sv/tcce_checker.sv
verif/testbench.sv
